// ===== hw/rtl/smsort_pkg.sv =====
// Shared types for the stable descending merge sorter.
// Holds the controller state encoding and the command/status bundles.
// No dependencies.
package smsort_pkg;

    localparam int REC_W   = 64;
    localparam int SCORE_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_PRIME,
        ST_MERGE,
        ST_OUT_PRIME,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_beat;   // input beat accepted
        logic out_prime;   // fetch the first sorted record
        logic prime;       // set up pointers of the next run pair
        logic merge;       // move one record into the destination bank
        logic out_active;  // output beat on offer
        logic out_beat;    // output beat accepted
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic width_ge_n;  // run width covers the whole set
        logic run_last;    // this merge step ends the run pair
        logic pass_last;   // this run pair ends the pass
        logic out_last;    // output beat holds the final record
    } status_t;

endpackage

// ===== hw/rtl/smsort_ctrl.sv =====
// Controller state machine of the merge sorter.
// Sequences load, merge passes and output; depends on smsort_pkg.
module smsort_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  logic                s_last,
    input  logic                m_ready,
    input  smsort_pkg::status_t status,
    output logic                s_ready,
    output logic                m_valid,
    output smsort_pkg::cmd_t    cmd
);

    smsort_pkg::state_t state_reg;
    smsort_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smsort_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            smsort_pkg::ST_LOAD:
            begin
                s_ready       = 1'b1;
                cmd.load_beat = s_valid;
                if (s_valid && s_last)
                begin
                    state_next = smsort_pkg::ST_PASS_INIT;
                end
            end
            smsort_pkg::ST_PASS_INIT:
            begin
                if (status.width_ge_n)
                begin
                    state_next = smsort_pkg::ST_OUT_PRIME;
                end
                else
                begin
                    state_next = smsort_pkg::ST_PRIME;
                end
            end
            smsort_pkg::ST_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = smsort_pkg::ST_MERGE;
            end
            smsort_pkg::ST_MERGE:
            begin
                cmd.merge = 1'b1;
                if (status.run_last)
                begin
                    state_next = status.pass_last ? smsort_pkg::ST_PASS_INIT
                                                  : smsort_pkg::ST_PRIME;
                end
            end
            smsort_pkg::ST_OUT_PRIME:
            begin
                cmd.out_prime = 1'b1;
                state_next    = smsort_pkg::ST_OUT;
            end
            smsort_pkg::ST_OUT:
            begin
                m_valid        = 1'b1;
                cmd.out_active = 1'b1;
                cmd.out_beat   = m_ready;
                if (m_ready && status.out_last)
                begin
                    state_next = smsort_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = smsort_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== hw/rtl/smsort_datapath.sv =====
// Datapath of the merge sorter: two record banks, run pointers, comparator.
// Banks alternate as source and destination on each pass; depends on smsort_pkg.
module smsort_datapath
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  smsort_pkg::cmd_t             cmd,
    input  logic [smsort_pkg::REC_W-1:0] s_data,
    output smsort_pkg::status_t          status,
    output logic [smsort_pkg::REC_W-1:0] m_data,
    output logic                         m_last
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 1;
    localparam int RW = smsort_pkg::REC_W;
    localparam int SW = smsort_pkg::SCORE_W;

    // Record banks
    logic [RW-1:0] bank0_mem [MAX_ITEMS];
    logic [RW-1:0] bank1_mem [MAX_ITEMS];
    logic [RW-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] width_reg, width_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;

    logic [RW-1:0] rd_a, rd_b;
    logic [RW-1:0] merge_data;
    logic          take_left;
    logic [PW-1:0] n_ext;
    logic [PW-1:0] mid_sum, hi_sum;
    logic [CW-1:0] mid_calc, hi_calc;
    logic [CW-1:0] k_inc;
    logic [CW-1:0] addr_a, addr_b;
    logic          load_wr;
    logic          we0, we1;
    logic [AW-1:0] wa0;
    logic [RW-1:0] wd0;

    assign rd_a  = src_reg ? rd1a_reg : rd0a_reg;
    assign rd_b  = src_reg ? rd1b_reg : rd0b_reg;
    assign n_ext = {1'b0, count_reg};
    assign k_inc = k_reg + CW'(1);

    // Bounds of the next run pair, clamped to the set size
    assign mid_sum  = lo_reg + width_reg;
    assign hi_sum   = lo_reg + {width_reg[PW-2:0], 1'b0};
    assign mid_calc = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
    assign hi_calc  = (hi_sum > n_ext) ? count_reg : hi_sum[CW-1:0];

    // Pick the left head on ties so earlier records stay first
    always_comb
    begin
        priority if (a_reg >= mid_reg)
        begin
            take_left = 1'b0;
        end
        else if (b_reg >= hi_reg)
        begin
            take_left = 1'b1;
        end
        else
        begin
            take_left = $signed(rd_a[SW-1:0]) >= $signed(rd_b[SW-1:0]);
        end
    end

    assign merge_data = take_left ? rd_a : rd_b;

    assign status.width_ge_n = width_reg >= n_ext;
    assign status.run_last   = k_inc == hi_reg;
    assign status.pass_last  = hi_reg == count_reg;
    assign status.out_last   = k_inc == count_reg;

    assign m_data = rd_a;
    assign m_last = status.out_last;

    // Pointer and counter updates
    always_comb
    begin
        count_next = count_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        load_wr    = 1'b0;
        addr_a     = a_reg;
        addr_b     = b_reg;

        if (cmd.load_beat)
        begin
            load_wr = count_reg < CW'(MAX_ITEMS);
            if (load_wr)
            begin
                count_next = count_reg + CW'(1);
            end
            width_next = PW'(1);
            lo_next    = '0;
            src_next   = 1'b0;
        end

        if (cmd.prime)
        begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            a_next   = lo_reg[CW-1:0];
            b_next   = mid_calc;
            k_next   = lo_reg[CW-1:0];
            addr_a   = lo_reg[CW-1:0];
            addr_b   = mid_calc;
        end

        if (cmd.merge)
        begin
            k_next = k_inc;
            if (take_left)
            begin
                a_next = a_reg + CW'(1);
            end
            else
            begin
                b_next = b_reg + CW'(1);
            end
            addr_a = a_next;
            addr_b = b_next;
            if (status.run_last)
            begin
                if (status.pass_last)
                begin
                    src_next   = ~src_reg;
                    width_next = {width_reg[PW-2:0], 1'b0};
                    lo_next    = '0;
                end
                else
                begin
                    lo_next = hi_sum;
                end
            end
        end

        if (cmd.out_prime)
        begin
            k_next = '0;
            addr_a = '0;
        end

        if (cmd.out_active)
        begin
            addr_a = k_reg;
            if (cmd.out_beat)
            begin
                k_next = k_inc;
                addr_a = k_inc;
                if (status.out_last)
                begin
                    count_next = '0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            width_reg <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            src_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            width_reg <= width_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            k_reg     <= k_next;
            src_reg   <= src_next;
        end
    end

    // Bank write steering: loads go to bank 0, merges to the non-source bank
    assign we0 = load_wr | (cmd.merge & src_reg);
    assign we1 = cmd.merge & ~src_reg;
    assign wa0 = load_wr ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wd0 = load_wr ? s_data : merge_data;

    // Bank 0
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[wa0] <= wd0;
        end
        rd0a_reg <= bank0_mem[addr_a[AW-1:0]];
        rd0b_reg <= bank0_mem[addr_b[AW-1:0]];
    end

    // Bank 1
    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_mem[k_reg[AW-1:0]] <= merge_data;
        end
        rd1a_reg <= bank1_mem[addr_a[AW-1:0]];
        rd1b_reg <= bank1_mem[addr_b[AW-1:0]];
    end

endmodule

// ===== hw/rtl/stable_descending_merge_sort.sv =====
// Stable descending merge sorter, top level.
// Instantiates smsort_ctrl and smsort_datapath; depends on smsort_pkg.
//
// Usage:
//   Records enter on the s_axis channel, one per beat, and are stored in
//   order. The beat with s_axis_tlast set closes the set (its record is
//   stored first) and starts a bottom-up merge sort by descending score;
//   on equal scores the earlier record comes out first. Records beyond
//   MAX_ITEMS are dropped, but a dropped tlast beat still starts the sort.
//   Sorted records leave on m_axis, one per beat, tlast on the final one.
//   Loading accepts a beat whenever s_axis_tvalid is high. Each merge pass
//   primes and merges each run pair in turn, one merge step per cycle
//   through the two-port bank read, until the run width covers the set.
//   Output then fetches the first sorted record and sends one per beat.
//   s_axis_tready is low from the tlast beat until the final output beat.
//   A stall on m_axis holds the current record; the read re-fetches the
//   same entry each cycle. Reset empties the set and returns to loading.
module stable_descending_merge_sort
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] score, [63:32] payload
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] sorted_score, [63:32] sorted_payload
    output logic        m_axis_tlast    // final_record
);

    smsort_pkg::cmd_t    cmd;
    smsort_pkg::status_t status;

    smsort_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .m_ready (m_axis_tready),
        .status  (status),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .cmd     (cmd)
    );

    smsort_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .s_data (s_axis_tdata),
        .status (status),
        .m_data (m_axis_tdata),
        .m_last (m_axis_tlast)
    );

    // Loading and output never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
    else $error("input and output active together");

    // A closing input beat ends loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("still loading after closing beat");

    // The final output beat returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !m_axis_tvalid))
    else $error("not back to loading after final record");

endmodule
